FILE: rtl/riff_wave_chunk_parser_core_defines.svh
// Assertion macros for the WAV chunk parser.
// Included by the top level; depends on nothing else.
`ifndef RIFF_WAVE_CHUNK_PARSER_CORE_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_CORE_DEFINES_SVH
// assert that a condition implies a property on the same clock
`define RWP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// assert that a condition implies a property on the following clock
`define RWP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: rtl/rwp_pkg.sv
// Shared types and constants for the WAV chunk parser.
// No dependencies.
package rwp_pkg;
  localparam int unsigned CountWidth = 31;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StSig    = 3'd1;
  localparam logic [2:0] StLen    = 3'd2;
  localparam logic [2:0] StFmt    = 3'd3;
  localparam logic [2:0] StDupFmt = 3'd4;
  localparam logic [2:0] StNoFmt  = 3'd5;
  localparam logic [2:0] StNoData = 3'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [30:0] sample_rate;
    logic [15:0] sample_bits;
    logic [30:0] sample_count;
    logic [30:0] frame_count;
    logic        run_end;
  } out_item_t;

  // front-to-back command: either a payload byte, a summary request, or both
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay;
    logic        has_sum;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [30:0] rate;
    logic [15:0] bits;
    logic [30:0] data_bytes;
  } cmd_t;
endpackage

FILE: rtl/rwp_front.sv
// Front end: walks the RIFF/WAVE byte stream and classifies each byte.
// Depends on rwp_pkg.
module rwp_front import rwp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);
  localparam logic [2:0] PhRiff = 3'd0;
  localparam logic [2:0] PhSize = 3'd1;
  localparam logic [2:0] PhWave = 3'd2;
  localparam logic [2:0] PhHdr  = 3'd3;
  localparam logic [2:0] PhBody = 3'd4;
  localparam logic [2:0] PhTail = 3'd5;
  localparam logic [2:0] PhErr  = 3'd6;

  localparam logic [1:0] CkOther = 2'd0;
  localparam logic [1:0] CkFmt   = 2'd1;
  localparam logic [1:0] CkData  = 2'd2;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] riff_q, riff_d;
  logic [1:0]  ck_q, ck_d;
  logic [31:0] crem_q, crem_d;
  logic [15:0] tag_q, tag_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [30:0] dbytes_q, dbytes_d;
  logic [2:0]  err_q, err_d;

  logic [7:0] b;
  logic [1:0] p2;
  logic [31:0] riff8;
  logic [32:0] dsum;
  logic [31:0] len;
  logic [7:0] exp_riff, exp_wave, exp_fmt, exp_data;

  assign b  = item_i.in_byte;
  assign p2 = pos_q[1:0];

  always_comb begin
    case (p2)
      2'd0: begin exp_riff = 8'h52; exp_wave = 8'h57; exp_fmt = 8'h66; exp_data = 8'h64; end
      2'd1: begin exp_riff = 8'h49; exp_wave = 8'h41; exp_fmt = 8'h6d; exp_data = 8'h61; end
      2'd2: begin exp_riff = 8'h46; exp_wave = 8'h56; exp_fmt = 8'h74; exp_data = 8'h74; end
      default: begin exp_riff = 8'h46; exp_wave = 8'h45; exp_fmt = 8'h20; exp_data = 8'h61; end
    endcase
  end

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; riff_d = riff_q; ck_d = ck_q; crem_d = crem_q;
    tag_d = tag_q; ch_d = ch_q; rate_d = rate_q; bits_d = bits_q;
    dbytes_d = dbytes_q; err_d = err_q;
    riff8 = riff_q - 32'd8;
    len = crem_q;
    dsum = {2'b0, dbytes_q} + {1'b0, len};
    cmd_o = '0;
    cmd_o.pay = b;
    case (phase_q)
      PhRiff: begin
        if (b != exp_riff) begin
          err_d = StSig; phase_d = PhErr;
        end else if (pos_q == 5'd3) begin
          pos_d = '0; phase_d = PhSize;
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
      PhSize: begin
        riff_d = riff_q | ({24'd0, b} << {p2, 3'b000});
        if (pos_q == 5'd3) begin
          pos_d = '0;
          if (riff_d[31] || riff_d < 32'd4) begin
            err_d = StLen; phase_d = PhErr;
          end else begin
            phase_d = PhWave;
          end
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
      PhWave: begin
        if (b != exp_wave) begin
          err_d = StSig; phase_d = PhErr;
        end else begin
          riff_d = riff_q - 32'd1;
          if (pos_q == 5'd3) begin
            pos_d = '0; ck_d = CkOther; crem_d = '0;
            phase_d = (riff_d == 32'd0) ? PhTail : PhHdr;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
      end
      PhHdr: begin
        if (pos_q == 5'd0 && riff_q < 32'd8) begin
          err_d = StLen; phase_d = PhErr;
        end else begin
          if (pos_q == 5'd0) begin
            ck_d = (b == 8'h66) ? CkFmt : ((b == 8'h64) ? CkData : CkOther);
          end else if (pos_q < 5'd4) begin
            if (ck_q == CkFmt && b != exp_fmt) ck_d = CkOther;
            if (ck_q == CkData && b != exp_data) ck_d = CkOther;
          end else begin
            crem_d = crem_q | ({24'd0, b} << {p2, 3'b000});
          end
          pos_d = pos_q + 5'd1;
          if (pos_q == 5'd7) begin
            len = crem_d;
            dsum = {2'b0, dbytes_q} + {1'b0, len};
            riff_d = riff8;
            pos_d = '0;
            if (len[31] || len > riff8) begin
              err_d = StLen; phase_d = PhErr;
            end else if (ck_q == CkFmt && rate_q != 32'd0) begin
              err_d = StDupFmt; phase_d = PhErr;
            end else if (ck_q == CkFmt && len < 32'd16) begin
              err_d = StFmt; phase_d = PhErr;
            end else if (ck_q == CkData && dsum[32:31] != 2'b00) begin
              err_d = StLen; phase_d = PhErr;
            end else if (len == 32'd0) begin
              ck_d = CkOther; crem_d = '0;
              phase_d = (riff8 == 32'd0) ? PhTail : PhHdr;
            end else begin
              phase_d = PhBody;
            end
          end
        end
      end
      PhBody: begin
        riff_d = riff_q - 32'd1;
        crem_d = crem_q - 32'd1;
        if (ck_q == CkFmt) begin
          if (pos_q < 5'd16) begin
            if (pos_q < 5'd2) tag_d = tag_q | ({8'd0, b} << {pos_q[0], 3'b000});
            else if (pos_q < 5'd4) ch_d = ch_q | ({8'd0, b} << {pos_q[0], 3'b000});
            else if (pos_q < 5'd8) rate_d = rate_q | ({24'd0, b} << {p2, 3'b000});
            else if (pos_q >= 5'd14) bits_d = bits_q | ({8'd0, b} << {pos_q[0], 3'b000});
            pos_d = pos_q + 5'd1;
            if (pos_q == 5'd15 && (tag_q != 16'd1 || ch_q == 16'd0 || rate_q == 32'd0
                || rate_q[31] || bits_d == 16'd0 || bits_d[2:0] != 3'd0)) begin
              err_d = StFmt; phase_d = PhErr;
            end
          end
        end else if (ck_q == CkData) begin
          cmd_o.has_pay = 1'b1;
          dbytes_d = dbytes_q + 31'd1;
        end
        if (phase_d == PhBody && crem_d == 32'd0) begin
          pos_d = '0; ck_d = CkOther; crem_d = '0;
          phase_d = (riff_d == 32'd0) ? PhTail : PhHdr;
        end
      end
      default: ;
    endcase
    if (item_i.in_last) begin
      cmd_o.has_sum = 1'b1;
      cmd_o.status = err_d;
      if (err_d == StOk && phase_d != PhTail) cmd_o.status = StLen;
      else if (err_d == StOk && rate_d == 32'd0) cmd_o.status = StNoFmt;
      else if (err_d == StOk && dbytes_d == 31'd0) cmd_o.status = StNoData;
      cmd_o.channels = ch_d;
      cmd_o.rate = rate_d[30:0];
      cmd_o.bits = bits_d;
      cmd_o.data_bytes = dbytes_d;
      phase_d = PhRiff; pos_d = '0; riff_d = '0; ck_d = CkOther; crem_d = '0;
      tag_d = '0; ch_d = '0; rate_d = '0; bits_d = '0; dbytes_d = '0; err_d = StOk;
    end
  end

  assign cmd_valid_o = valid_i && (cmd_o.has_pay || cmd_o.has_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRiff; pos_q <= '0; riff_q <= '0; ck_q <= CkOther; crem_q <= '0;
      tag_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0; dbytes_q <= '0; err_q <= StOk;
    end else if (valid_i) begin
      phase_q <= phase_d; pos_q <= pos_d; riff_q <= riff_d; ck_q <= ck_d; crem_q <= crem_d;
      tag_q <= tag_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
      dbytes_q <= dbytes_d; err_q <= err_d;
    end
  end
endmodule

FILE: rtl/rwp_cmdq.sv
// Short command queue between front and back ends.
// Depends on rwp_pkg.
module rwp_cmdq import rwp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output cmd_t data_o
);
  cmd_t mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == 3'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 3'(push_i && !full_o) - 3'(pop_i && !empty_o);
    end
  end
endmodule

FILE: rtl/rwp_back.sv
// Back end: emits payload items and summaries; an ok summary uses two serial divides.
// Depends on rwp_pkg.
module rwp_back import rwp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv1 = 2'd1;
  localparam logic [1:0] SDiv2 = 2'd2;
  localparam logic [1:0] SSum  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic        pay_done_q, pay_done_d;
  logic        full_q, full_d;
  out_item_t   out_q, out_d;
  logic [30:0] quo_q, quo_d;
  logic [30:0] rem_q, rem_d;
  logic [30:0] num_q, num_d;
  logic [15:0] div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] sc_q, sc_d;
  logic [31:0] trial;
  logic        out_free;
  logic        summ_ok;

  assign out_free = !full_q || pop_i;
  assign empty_o  = !full_q;
  assign item_o   = out_q;
  assign summ_ok  = (cmd_i.status == StOk);
  assign trial    = {rem_q, num_q[30]} - {16'd0, div_q};

  always_comb begin
    st_d = st_q; pay_done_d = pay_done_q; full_d = full_q && !pop_i;
    out_d = out_q; quo_d = quo_q; rem_d = rem_q; num_d = num_q;
    div_d = div_q; cnt_d = cnt_q; sc_d = sc_q;
    cmd_pop_o = 1'b0;
    case (st_q)
      SIdle: begin
        if (!cmd_empty_i && out_free) begin
          if (cmd_i.has_pay && !pay_done_q) begin
            out_d = '0;
            out_d.payload = cmd_i.pay;
            out_d.run_end = !cmd_i.has_sum;
            full_d = 1'b1;
            pay_done_d = cmd_i.has_sum;
            cmd_pop_o = !cmd_i.has_sum;
          end else begin
            pay_done_d = 1'b0;
            if (summ_ok) begin
              st_d = SDiv1;
              num_d = cmd_i.data_bytes; rem_d = '0; quo_d = '0; cnt_d = '0;
              div_d = {3'd0, cmd_i.bits[15:3]};
            end else begin
              out_d = '0;
              out_d.kind = 1'b1;
              out_d.status = cmd_i.status;
              out_d.run_end = 1'b1;
              full_d = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
      end
      SDiv1, SDiv2: begin
        num_d = {num_q[29:0], 1'b0};
        if (!trial[31]) begin
          rem_d = trial[30:0]; quo_d = {quo_q[29:0], 1'b1};
        end else begin
          rem_d = {rem_q[29:0], num_q[30]}; quo_d = {quo_q[29:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          if (st_q == SDiv1) begin
            sc_d = quo_d; num_d = quo_d;
            rem_d = '0; quo_d = '0; cnt_d = '0; div_d = cmd_i.channels;
            st_d = SDiv2;
          end else begin
            st_d = SSum;
          end
        end
      end
      SSum: begin
        if (out_free) begin
          out_d = '0;
          out_d.kind = 1'b1;
          out_d.channels = cmd_i.channels;
          out_d.sample_rate = cmd_i.rate;
          out_d.sample_bits = cmd_i.bits;
          out_d.sample_count = sc_q;
          out_d.frame_count = quo_q;
          out_d.run_end = 1'b1;
          full_d = 1'b1;
          st_d = SIdle;
          cmd_pop_o = 1'b1;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d; quo_q <= quo_d; rem_q <= rem_d; num_q <= num_d;
    div_q <= div_d; cnt_q <= cnt_d; sc_q <= sc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; pay_done_q <= 1'b0; full_q <= 1'b0;
    end else begin
      st_q <= st_d; pay_done_q <= pay_done_d; full_q <= full_d;
    end
  end
endmodule

FILE: rtl/riff_wave_chunk_parser_core.sv
// WAV/RIFF LPCM chunk parser, byte-stream in, payload and summary items out.
// Channels: input queue (push/full, item_i = byte and last flag) and
// output queue (empty/pop, item_o). Each input byte is classified in
// the front end; a data-chunk byte becomes one payload item (kind 0) queued
// into a 4-entry command queue, so payload bytes stream at one per cycle
// while neither the queue nor the receiver stalls. The final byte (in_last)
// adds a summary item (kind 1, run_end set). A summary with ok status needs
// two bit-serial 31-step divisions in the back end; an error summary needs
// none. A payload byte is registered in the queue, then in the output register.
// full rises when the command queue fills, e.g. while the divider runs or
// the receiver stalls; the output register holds its item until popped.
// Reset clears the parser state, the queue pointers and the output full flag;
// the block then expects a new "RIFF" signature. After each summary the parser
// returns to that same state for the next file.
`include "riff_wave_chunk_parser_core_defines.svh"
module riff_wave_chunk_parser_core import rwp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t item_o
);
  logic q_full, q_empty, q_pop, cmd_valid;
  cmd_t cmd_in, cmd_out;
  logic acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  rwp_front u_front (
    .clk_i, .rst_ni, .valid_i(acc), .item_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd_in)
  );

  rwp_cmdq u_q (
    .clk_i, .rst_ni, .push_i(cmd_valid), .data_i(cmd_in),
    .full_o(q_full), .empty_o(q_empty), .pop_i(q_pop), .data_o(cmd_out)
  );

  rwp_back u_back (
    .clk_i, .rst_ni, .cmd_empty_i(q_empty), .cmd_i(cmd_out), .cmd_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop), .item_o
  );

  `RWP_ASSERT_IMPL(a_pop_needs_cmd, clk_i, rst_ni, q_pop, !q_empty)
  `RWP_ASSERT_IMPL(a_summary_ends_run, clk_i, rst_ni, !empty && item_o.kind, item_o.run_end)
  `RWP_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, !empty && !pop, !empty && $stable(item_o))
endmodule

FILE: dv/testbench.sv
// Testbench for riff_wave_chunk_parser_core: streams WAV files byte by byte and
// checks every payload and summary item against a behavioral parser model.
// Depends on rwp_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import rwp_pkg::*;

  typedef enum logic [2:0] {
    PhRiff, PhSize, PhWave, PhHdr, PhBody, PhTail, PhErr
  } phase_e;

  localparam int unsigned WatchLimit = 20000;

  localparam logic [1:0] CkOther = 2'd0;
  localparam logic [1:0] CkFmt   = 2'd1;
  localparam logic [1:0] CkData  = 2'd2;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t item_o;

  riff_wave_chunk_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (item_i),
    .empty  (empty),
    .pop    (pop),
    .item_o (item_o)
  );

  // parser model state
  phase_e      ph;
  logic [4:0]  fpos;
  logic [31:0] riff_left;
  logic [1:0]  ckind;
  logic [31:0] chunk_left;
  logic [15:0] ftag;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [15:0] sbits;
  logic [31:0] dbytes;
  logic [2:0]  err;

  out_item_t wav_items_q[$];
  byte       file_q[$];
  int        errors;
  int        watch;

  function automatic void parser_clear();
    ph = PhRiff; fpos = 0; riff_left = 0; ckind = CkOther; chunk_left = 0;
    ftag = 0; chans = 0; rate = 0; sbits = 0; dbytes = 0; err = StOk;
  endfunction

  function automatic void parser_fail(logic [2:0] code);
    err = code;
    ph = PhErr;
  endfunction

  function automatic void chunk_next();
    fpos = 0; ckind = CkOther; chunk_left = 0;
    ph = (riff_left == 0) ? PhTail : PhHdr;
  endfunction

  function automatic void header_end();
    logic [31:0] len;
    len = chunk_left;
    riff_left -= 8;
    if (len[31] || len > riff_left) begin
      parser_fail(StLen);
      return;
    end
    if (ckind == CkFmt) begin
      if (rate != 0) begin
        parser_fail(StDupFmt);
        return;
      end
      if (len < 16) begin
        parser_fail(StFmt);
        return;
      end
    end else if (ckind == CkData) begin
      if (64'(dbytes) + 64'(len) > 64'h7fff_ffff) begin
        parser_fail(StLen);
        return;
      end
    end
    fpos = 0;
    if (len == 0) chunk_next();
    else ph = PhBody;
  endfunction

  function automatic void fmt_take(logic [7:0] b);
    int p;
    p = fpos;
    if (p >= 16) return;
    if (p < 2) ftag |= 16'(b) << (8 * p);
    else if (p < 4) chans |= 16'(b) << (8 * (p - 2));
    else if (p < 8) rate |= 32'(b) << (8 * (p - 4));
    else if (p >= 14) sbits |= 16'(b) << (8 * (p - 14));
    fpos = 5'(p + 1);
    if (p == 15 && (ftag != 1 || chans == 0 || rate == 0 || rate[31] ||
                    sbits == 0 || sbits[2:0] != 0))
      parser_fail(StFmt);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    out_item_t o;
    int p;
    logic [2:0] st;
    logic [31:0] ss, sc;
    p = fpos;
    case (ph)
      PhRiff: begin
        if (b != 8'("RIFF" >> (8 * (3 - p)))) parser_fail(StSig);
        else if (p == 3) begin
          fpos = 0; ph = PhSize;
        end else fpos = 5'(p + 1);
      end
      PhSize: begin
        riff_left |= 32'(b) << (8 * p);
        fpos = 5'(p + 1);
        if (p == 3) begin
          fpos = 0;
          if (riff_left[31] || riff_left < 4) parser_fail(StLen);
          else ph = PhWave;
        end
      end
      PhWave: begin
        if (b != 8'("WAVE" >> (8 * (3 - p)))) parser_fail(StSig);
        else begin
          riff_left--;
          fpos = 5'(p + 1);
          if (p == 3) chunk_next();
        end
      end
      PhHdr: begin
        if (p == 0 && riff_left < 8) parser_fail(StLen);
        else begin
          if (p == 0) ckind = (b == "f") ? CkFmt : (b == "d") ? CkData : CkOther;
          else if (p < 4) begin
            if (ckind == CkFmt && b != 8'("fmt " >> (8 * (3 - p)))) ckind = CkOther;
            if (ckind == CkData && b != 8'("data" >> (8 * (3 - p)))) ckind = CkOther;
          end else chunk_left |= 32'(b) << (8 * (p - 4));
          fpos = 5'(p + 1);
          if (p == 7) header_end();
        end
      end
      PhBody: begin
        riff_left--;
        chunk_left--;
        if (ckind == CkFmt) fmt_take(b);
        else if (ckind == CkData) begin
          o = '0;
          o.payload = b;
          o.run_end = !last;
          wav_items_q.push_back(o);
          dbytes++;
        end
        if (ph == PhBody && chunk_left == 0) chunk_next();
      end
      default: ;
    endcase
    if (last) begin
      st = err;
      if (st == StOk && ph != PhTail) st = StLen;
      if (st == StOk && rate == 0) st = StNoFmt;
      if (st == StOk && dbytes == 0) st = StNoData;
      o = '0;
      o.kind = 1;
      o.status = st;
      o.run_end = 1;
      if (st == StOk) begin
        ss = 32'(sbits >> 3);
        if (ss == 0) ss = 1;
        sc = dbytes / ss;
        o.channels = chans;
        o.sample_rate = rate[30:0];
        o.sample_bits = sbits;
        o.sample_count = sc[30:0];
        o.frame_count = 31'(sc / (chans != 0 ? chans : 1));
      end
      wav_items_q.push_back(o);
      parser_clear();
    end
  endfunction

  function automatic void put32(int unsigned v);
    for (int i = 0; i < 4; i++) file_q.push_back(byte'(v >> (8 * i)));
  endfunction

  function automatic void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_q.push_back(byte'(t >> (8 * i)));
  endfunction

  // build a mostly well-formed file, possibly corrupted, or nbytes random bytes
  function automatic void build_file(int nbytes);
    int unsigned body_len, dlen, flen, ch, bits, rt, r;
    file_q = {};
    dlen = $urandom_range(0, 12);
    flen = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : 16;
    ch = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 4);
    bits = 8 * $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) bits = $urandom_range(0, 65535);
    rt = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 96000);
    put_tag("RIFF");
    body_len = 4 + 8 + flen + 8 + dlen;
    if ($urandom_range(0, 3) == 0) body_len += 8 + 3;
    put32(body_len);
    put_tag("WAVE");
    if ($urandom_range(0, 3) == 0) begin
      put_tag("LIST"); put32(3);
      repeat (3) file_q.push_back(byte'($urandom));
    end
    put_tag("fmt "); put32(flen);
    file_q.push_back(($urandom_range(0, 9) == 0) ? 8'd3 : 8'd1);
    file_q.push_back(8'd0);
    file_q.push_back(byte'(ch)); file_q.push_back(byte'(ch >> 8));
    put32(rt);
    repeat (6) file_q.push_back(byte'($urandom));
    file_q.push_back(byte'(bits)); file_q.push_back(byte'(bits >> 8));
    repeat (int'(flen) - 16 > 0 ? flen - 16 : 0) file_q.push_back(byte'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      put_tag("fmt "); put32(16);
    end
    put_tag("data"); put32(dlen);
    repeat (dlen) file_q.push_back(byte'($urandom));
    repeat ($urandom_range(0, 2)) file_q.push_back(byte'($urandom));
    r = $urandom_range(0, 9);
    if (r == 0) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
    else if (r == 1) file_q[$urandom_range(0, file_q.size() - 1)] = byte'($urandom);
    if (nbytes > 0) begin
      file_q = {};
      repeat (nbytes) file_q.push_back(byte'($urandom));
    end
  endfunction

  task automatic send(logic [7:0] b, logic last);
    if ($urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= '{in_byte: b, in_last: last};
    do @(posedge clk_i); while (full);
    parse_byte(b, last);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send(file_q[i], i == file_q.size() - 1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, compare on accept
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (wav_items_q.size() == 0) begin
        $display("%0t unexpected item %h", $time, item_o);
        errors++;
      end else begin
        e = wav_items_q.pop_front();
        if (item_o !== e) begin
          $display("%0t mismatch expected %h actual %h", $time, e, item_o);
          errors++;
        end
      end
    end
    pop <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) watch <= 0;
    else watch <= watch + 1;
    if (watch > WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       check;
    logic [2:0] st;
  } row_t;

  row_t dir_rows[$];
  int sent;

  initial begin
    errors = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    parser_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: bad signature, tiny RIFF size, last right after reset, extremes
    dir_rows = '{
      '{8'hff, 1'b1, 1'b1, StSig},
      '{8'h00, 1'b1, 1'b1, StSig},
      '{"R", 1'b1, 1'b1, StLen},
      '{"R", 1'b0, 1'b0, StOk}, '{"I", 1'b0, 1'b0, StOk},
      '{"F", 1'b0, 1'b0, StOk}, '{"F", 1'b0, 1'b0, StOk},
      '{8'h03, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk}, '{8'h00, 1'b1, 1'b1, StLen},
      '{"R", 1'b0, 1'b0, StOk}, '{"I", 1'b0, 1'b0, StOk},
      '{"F", 1'b0, 1'b0, StOk}, '{"F", 1'b0, 1'b0, StOk},
      '{8'h04, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk}, '{8'h80, 1'b1, 1'b1, StLen},
      '{"R", 1'b0, 1'b0, StOk}, '{"I", 1'b0, 1'b0, StOk},
      '{"F", 1'b0, 1'b0, StOk}, '{"F", 1'b0, 1'b0, StOk},
      '{8'h04, 1'b0, 1'b0, StOk}, '{8'h00, 1'b1, 1'b1, StLen}
    };
    foreach (dir_rows[i]) begin
      send(dir_rows[i].b, dir_rows[i].last);
      if (dir_rows[i].check && wav_items_q[$].status != dir_rows[i].st) begin
        $display("%0t mismatch expected status %0d actual %0d", $time,
                 dir_rows[i].st, wav_items_q[$].status);
        errors++;
      end
    end
    push <= 1'b0;
    wait (wav_items_q.size() == 0);
    sent = 0;
    while (sent < 1400) begin
      build_file($urandom_range(0, 11) == 0 ? $urandom_range(1, 6) : 0);
      sent += file_q.size();
      send_file();
      if ($urandom_range(0, 19) == 0) begin
        push <= 1'b0;
        wait (wav_items_q.size() == 0);
        @(posedge clk_i);
      end
    end
    push <= 1'b0;
    wait (wav_items_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/rwp_pkg.sv
rtl/rwp_front.sv
rtl/rwp_cmdq.sv
rtl/rwp_back.sv
rtl/riff_wave_chunk_parser_core.sv
dv/testbench.sv
